### hdl/rv32se_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32se_pkg
// Shared types and constants for the rv32 subset executor.
// ----------------------------------------------------------------------------
package rv32se_pkg;

  localparam int XLEN_DEF      = 32;
  localparam int REG_COUNT_DEF = 32;
  localparam int LEN_W         = 30;
  localparam int SHAMT_W       = 5;
  localparam logic [31:0] PC_STEP = 32'd4;

  typedef enum logic [4:0] {
    OP_LI   = 5'd0,  OP_LW   = 5'd1,  OP_SW   = 5'd2,  OP_ADD  = 5'd3,
    OP_AND  = 5'd4,  OP_DIV  = 5'd5,  OP_MUL  = 5'd6,  OP_REM  = 5'd7,
    OP_OR   = 5'd8,  OP_SLL  = 5'd9,  OP_SRL  = 5'd10, OP_SUB  = 5'd11,
    OP_XOR  = 5'd12, OP_ADDI = 5'd13, OP_ANDI = 5'd14, OP_ORI  = 5'd15,
    OP_SLLI = 5'd16, OP_SRLI = 5'd17, OP_XORI = 5'd18, OP_BEQ  = 5'd19,
    OP_BNE  = 5'd20
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the input beat
    logic read_a;    // register file read of operand a
    logic read_b;    // register file read of operand b
    logic execute;   // non-iterative ops and mul/div start
    logic step;      // one mul/div iteration
    logic finish;    // write back, update pc, load output register
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic iter_op;   // mul, div or rem
    logic iter_done; // last iteration reached
  } stat_t;

endpackage
`default_nettype wire

### hdl/rv32se_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32se_datapath
// Register file, pc, alu, iterative mul/div unit and output register.
// ----------------------------------------------------------------------------
module rv32se_datapath #(
  parameter int XLEN      = rv32se_pkg::XLEN_DEF,
  parameter int REG_COUNT = rv32se_pkg::REG_COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rv32se_pkg::ctrl_t         ctrl,
  output rv32se_pkg::stat_t              stat,
  input  wire logic [4:0]                func,
  input  wire logic [$clog2(REG_COUNT)-1:0] dest_reg,
  input  wire logic [$clog2(REG_COUNT)-1:0] src_reg_a,
  input  wire logic [$clog2(REG_COUNT)-1:0] src_reg_b,
  input  wire logic signed [XLEN-1:0]    immediate,
  input  wire logic [rv32se_pkg::LEN_W-1:0] program_length,
  output logic [XLEN-1:0]                fetch_address,
  output logic                           data_access_valid,
  output logic [XLEN-1:0]                data_address,
  output logic [XLEN-1:0]                next_pc,
  output logic                           halted
);
  import rv32se_pkg::*;

  localparam int IDX_W = $clog2(REG_COUNT);
  localparam int CNT_W = $clog2(XLEN + 1);

  logic [XLEN-1:0]  regs [REG_COUNT];
  logic [XLEN-1:0]  pc;
  logic [4:0]       op;
  logic [IDX_W-1:0] rd, ra, rb;
  logic [XLEN-1:0]  imm;
  logic [XLEN-1:0]  a, b;
  logic [XLEN-1:0]  res;
  logic             wr_en;
  logic [XLEN-1:0]  npc;
  logic [XLEN-1:0]  daddr;
  logic             dvalid;
  // mul/div working registers
  logic [XLEN-1:0]  acc, quo, opnd;
  logic [CNT_W-1:0] cnt;
  logic [XLEN:0]    rem_shift;
  logic [XLEN:0]    rem_diff;
  // reset value of the register file is held by valid bits
  logic [REG_COUNT-1:0] vld;
  logic [XLEN-1:0]  av, bv;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      op  <= func;
      rd  <= dest_reg;
      ra  <= src_reg_a;
      rb  <= src_reg_b;
      imm <= immediate;
    end
    if (ctrl.read_a) begin
      a <= (ra == '0) ? '0 : regs[ra];
    end
    if (ctrl.read_b) begin
      b <= (rb == '0) ? '0 : regs[rb];
    end
    if (ctrl.finish && wr_en && rd != '0) begin
      regs[rd] <= res;
    end
  end

  assign av = vld[ra] ? a : '0;
  assign bv = vld[rb] ? b : '0;

  assign stat.iter_op   = (op == OP_MUL) || (op == OP_DIV) || (op == OP_REM);
  assign stat.iter_done = (cnt == CNT_W'(XLEN));

  assign rem_shift = {acc, quo[XLEN-1]};
  assign rem_diff  = rem_shift - {1'b0, bv};

  // iterative unit: shift-add multiply, restoring divide
  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      cnt  <= '0;
      acc  <= '0;
      quo  <= av;
      opnd <= av;
    end else if (ctrl.step) begin
      cnt <= cnt + CNT_W'(1);
      if (op == OP_MUL) begin
        if (opnd[0]) acc <= acc + (bv << cnt);
        opnd <= opnd >> 1;
      end else begin
        if (!rem_diff[XLEN]) begin
          acc <= rem_diff[XLEN-1:0];
          quo <= {quo[XLEN-2:0], 1'b1};
        end else begin
          acc <= rem_shift[XLEN-1:0];
          quo <= {quo[XLEN-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    res    = '0;
    wr_en  = 1'b1;
    npc    = pc + PC_STEP;
    dvalid = 1'b0;
    daddr  = '0;
    case (op)
      OP_LI:   res = imm;
      OP_LW, OP_SW: begin
        wr_en  = 1'b0;
        dvalid = 1'b1;
        daddr  = av + imm;
      end
      OP_ADD:  res = av + bv;
      OP_AND:  res = av & bv;
      OP_DIV:  res = (bv == '0) ? '1 : quo;
      OP_MUL:  res = acc;
      OP_REM:  res = (bv == '0) ? av : acc;
      OP_OR:   res = av | bv;
      OP_SLL:  res = av << bv[SHAMT_W-1:0];
      OP_SRL:  res = av >> bv[SHAMT_W-1:0];
      OP_SUB:  res = av - bv;
      OP_XOR:  res = av ^ bv;
      OP_ADDI: res = av + imm;
      OP_ANDI: res = av & imm;
      OP_ORI:  res = av | imm;
      OP_SLLI: res = av << imm[SHAMT_W-1:0];
      OP_SRLI: res = av >> imm[SHAMT_W-1:0];
      OP_XORI: res = av ^ imm;
      OP_BEQ: begin
        wr_en = 1'b0;
        if (av == bv) npc = pc + imm;
      end
      OP_BNE: begin
        wr_en = 1'b0;
        if (av != bv) npc = pc + imm;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= '0;
      vld <= '0;
    end else if (ctrl.finish) begin
      pc <= npc;
      if (wr_en && rd != '0) vld[rd] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      fetch_address     <= pc;
      data_access_valid <= dvalid;
      data_address      <= daddr;
      next_pc           <= npc;
      halted            <= {2'b00, npc} >= {2'b00, program_length, 2'b00};
    end
  end

endmodule
`default_nettype wire

### hdl/rv32se_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32se_ctrl
// Sequencer for one instruction: capture, read, execute, iterate for mul/div, retire.
// ----------------------------------------------------------------------------
module rv32se_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rv32se_pkg::ctrl_t      ctrl,
  input  wire rv32se_pkg::stat_t stat
);
  import rv32se_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_ITER, S_DONE
  } state_t;

  state_t state;
  logic   accept;

  // a beat is accepted only while idle; the output register frees as soon as its beat is taken
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ctrl         = '0;
    ctrl.capture = accept;
    ctrl.read_a  = (state == S_READ);
    ctrl.read_b  = (state == S_READ);
    ctrl.execute = (state == S_EXEC);
    ctrl.step    = (state == S_ITER) && !stat.iter_done;
    ctrl.finish  = (state == S_DONE) && !(out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.finish) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (accept) state <= S_READ;
        S_READ: state <= S_EXEC;
        S_EXEC: state <= stat.iter_op ? S_ITER : S_DONE;
        S_ITER: if (stat.iter_done) state <= S_DONE;
        S_DONE: begin
          if (ctrl.finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/rv32_subset_executor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32_subset_executor_top
// Executes one pre-decoded rv32 subset instruction per input beat.
// ----------------------------------------------------------------------------
// An instruction goes from accepted beat to result through capture, register
// file read, execute and retire; mul, div and rem iterate after execute in
// the one-bit-per-cycle shift-add / restoring divide unit. One instruction
// is in flight at a time; the result register lets the next beat enter
// while a result still waits. program_length must be written only while
// idle, through cfg_valid/cfg_ready; the block itself does not enforce it.
module rv32_subset_executor_top #(
  parameter int XLEN      = rv32se_pkg::XLEN_DEF,
  parameter int REG_COUNT = rv32se_pkg::REG_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [rv32se_pkg::LEN_W-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [4:0]                   func,
  input  wire logic [$clog2(REG_COUNT)-1:0] dest_reg,
  input  wire logic [$clog2(REG_COUNT)-1:0] src_reg_a,
  input  wire logic [$clog2(REG_COUNT)-1:0] src_reg_b,
  input  wire logic signed [XLEN-1:0]       immediate,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [XLEN-1:0]                   fetch_address,
  output logic                              data_access_valid,
  output logic [XLEN-1:0]                   data_address,
  output logic [XLEN-1:0]                   next_pc,
  output logic                              halted
);
  import rv32se_pkg::*;

  ctrl_t            ctrl;
  stat_t            stat;
  logic [LEN_W-1:0] program_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      program_length <= cfg_data;
    end
  end

  rv32se_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  rv32se_datapath #(
    .XLEN      (XLEN),
    .REG_COUNT (REG_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .stat              (stat),
    .func              (func),
    .dest_reg          (dest_reg),
    .src_reg_a         (src_reg_a),
    .src_reg_b         (src_reg_b),
    .immediate         (immediate),
    .program_length    (program_length),
    .fetch_address     (fetch_address),
    .data_access_valid (data_access_valid),
    .data_address      (data_address),
    .next_pc           (next_pc),
    .halted            (halted)
  );

endmodule
`default_nettype wire
